@@ rtl/art_pkg.sv @@
// Package for the ARQ retransmit tracker: sizes, command and result codes,
// controller states and the controller/datapath command and status structs.
// No dependencies.
package art_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int PEND_W      = 6;
   localparam int ID_W        = 32;
   localparam int AGE_W       = 16;
   localparam int ENTRY_W     = 2 * ID_W;

   localparam logic [AGE_W-1:0] RETRY_AGE_RESET = AGE_W'(4);

   typedef enum logic [1:0] {
      CMD_SEND = 2'd0,
      CMD_ACK  = 2'd1,
      CMD_DATA = 2'd2,
      CMD_TICK = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_SENT      = 3'd0,
      KIND_RETX      = 3'd1,
      KIND_ACK_HIT   = 3'd2,
      KIND_ACK_MISS  = 3'd3,
      KIND_FULL      = 3'd4,
      KIND_ACK_REPLY = 3'd5,
      KIND_TICK_DONE = 3'd6
   } kind_type;

   typedef enum logic [1:0] {
      RD_FIRST,
      RD_NEXT,
      RD_TAIL
   } rd_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEND,
      ST_DATA,
      ST_ACK_SCAN,
      ST_ACK_MOVE,
      ST_ACK_MISS,
      ST_TICK_SCAN,
      ST_TICK_DONE
   } state_type;

   typedef struct packed {
      logic       latch;
      logic       tick;
      logic       idx_clr;
      logic       idx_inc;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       do_send;
      logic       do_retx;
      logic       do_move;
      logic       emit;
      kind_type   kind;
      logic       last;
   } dp_cmd_type;

   typedef struct packed {
      logic pending_zero;
      logic full;
      logic id_match;
      logic at_tail;
      logic age_due;
      logic out_free;
   } dp_status_type;

endpackage

@@ rtl/art_if.sv @@
// Valid/ready channel interfaces of the ARQ retransmit tracker:
// request, response and configuration write. Depends on art_pkg.
interface art_req_if import art_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [1:0]      cmd;
   logic [ID_W-1:0] frame_id;

   modport source (output valid, cmd, frame_id, input ready);
   modport sink   (input valid, cmd, frame_id, output ready);
endinterface

interface art_rsp_if import art_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [2:0]        kind;
   logic [ID_W-1:0]   msg_id;
   logic [PEND_W-1:0] pending_count;
   logic [ID_W-1:0]   transmit_total;
   logic              last;

   modport source (output valid, kind, msg_id, pending_count, transmit_total, last,
                   input ready);
   modport sink   (input valid, kind, msg_id, pending_count, transmit_total, last,
                   output ready);
endinterface

interface art_csr_if import art_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [AGE_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

@@ rtl/art_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with
// registered, enabled read data. No dependencies.
module art_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/art_ctrl.sv @@
// Controller state machine of the ARQ retransmit tracker: sequences send,
// ack search, data reply and tick scan. Depends on art_pkg.
module art_ctrl import art_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [1:0]    req_cmd,
   output logic          req_ready,
   input  dp_status_type sts,
   output dp_cmd_type    ctl
);

   state_type state_ff, state_in;
   cmd_type   req_code;

   assign req_code = cmd_type'(req_cmd);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      ctl        = '0;
      ctl.rd_sel = RD_FIRST;
      ctl.kind   = KIND_SENT;
      req_ready  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.latch   = 1'b1;
               ctl.idx_clr = 1'b1;
               unique case (req_code)
                  CMD_SEND: state_in = ST_SEND;
                  CMD_DATA: state_in = ST_DATA;
                  CMD_ACK: begin
                     if (sts.pending_zero) begin
                        state_in = ST_ACK_MISS;
                     end else begin
                        ctl.rd_en = 1'b1;
                        state_in  = ST_ACK_SCAN;
                     end
                  end
                  CMD_TICK: begin
                     ctl.tick = 1'b1;
                     if (sts.pending_zero) begin
                        state_in = ST_TICK_DONE;
                     end else begin
                        ctl.rd_en = 1'b1;
                        state_in  = ST_TICK_SCAN;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_SEND: begin
            if (sts.out_free) begin
               ctl.emit = 1'b1;
               ctl.last = 1'b1;
               if (sts.full) begin
                  ctl.kind = KIND_FULL;
               end else begin
                  ctl.kind    = KIND_SENT;
                  ctl.do_send = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         ST_DATA: begin
            if (sts.out_free) begin
               ctl.emit = 1'b1;
               ctl.last = 1'b1;
               ctl.kind = KIND_ACK_REPLY;
               state_in = ST_IDLE;
            end
         end
         ST_ACK_SCAN: begin
            priority if (sts.id_match) begin
               ctl.rd_en  = 1'b1;
               ctl.rd_sel = RD_TAIL;
               state_in   = ST_ACK_MOVE;
            end else if (sts.at_tail) begin
               state_in = ST_ACK_MISS;
            end else begin
               ctl.idx_inc = 1'b1;
               ctl.rd_en   = 1'b1;
               ctl.rd_sel  = RD_NEXT;
            end
         end
         ST_ACK_MOVE: begin
            if (sts.out_free) begin
               ctl.do_move = 1'b1;
               ctl.emit    = 1'b1;
               ctl.last    = 1'b1;
               ctl.kind    = KIND_ACK_HIT;
               state_in    = ST_IDLE;
            end
         end
         ST_ACK_MISS: begin
            if (sts.out_free) begin
               ctl.emit = 1'b1;
               ctl.last = 1'b1;
               ctl.kind = KIND_ACK_MISS;
               state_in = ST_IDLE;
            end
         end
         ST_TICK_SCAN: begin
            if (!sts.age_due || sts.out_free) begin
               if (sts.age_due) begin
                  ctl.do_retx = 1'b1;
                  ctl.emit    = 1'b1;
                  ctl.kind    = KIND_RETX;
               end
               if (sts.at_tail) begin
                  state_in = ST_TICK_DONE;
               end else begin
                  ctl.idx_inc = 1'b1;
                  ctl.rd_en   = 1'b1;
                  ctl.rd_sel  = RD_NEXT;
               end
            end
         end
         ST_TICK_DONE: begin
            if (sts.out_free) begin
               ctl.emit = 1'b1;
               ctl.last = 1'b1;
               ctl.kind = KIND_TICK_DONE;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

@@ rtl/art_dp.sv @@
// Datapath of the ARQ retransmit tracker: entry table RAM, counters,
// retry age register and the response output register. Depends on art_pkg, art_ram.
module art_dp import art_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  dp_cmd_type       ctl,
   output dp_status_type    sts,
   input  logic [ID_W-1:0]  req_frame_id,
   input  logic             csr_valid,
   input  logic [AGE_W-1:0] csr_data,
   art_rsp_if.source        rsp_chan
);

   logic [ID_W-1:0]    fid_ff;
   logic [CNT_W-1:0]   pending_ff, pending_in;
   logic [ID_W-1:0]    next_id_ff, next_id_in;
   logic [ID_W-1:0]    now_ff, now_in;
   logic [ID_W-1:0]    tx_ff, tx_in;
   logic [AGE_W-1:0]   age_ff;
   logic [IDX_W-1:0]   idx_ff;

   logic               rsp_valid_ff;
   kind_type           kind_ff;
   logic [ID_W-1:0]    msg_ff, msg_in;
   logic [PEND_W-1:0]  pcnt_ff;
   logic [ID_W-1:0]    total_ff;
   logic               last_ff;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr, rd_addr, tail_idx;
   logic [ENTRY_W-1:0] wr_data, rd_data;
   logic [ID_W-1:0]    rd_id, rd_time, age;
   logic [CNT_W-1:0]   tail_cnt;

   assign rd_id    = rd_data[ENTRY_W-1:ID_W];
   assign rd_time  = rd_data[ID_W-1:0];
   assign tail_cnt = pending_ff - CNT_W'(1);
   assign tail_idx = tail_cnt[IDX_W-1:0];
   assign age      = now_ff - rd_time;

   assign now_in     = ctl.tick ? now_ff + ID_W'(1) : now_ff;
   assign next_id_in = ctl.do_send ? next_id_ff + ID_W'(1) : next_id_ff;
   assign tx_in      = (ctl.do_send || ctl.do_retx) ? tx_ff + ID_W'(1) : tx_ff;

   always_comb begin
      pending_in = pending_ff;
      if (ctl.do_send) begin
         pending_in = pending_ff + CNT_W'(1);
      end else if (ctl.do_move) begin
         pending_in = tail_cnt;
      end
   end

   always_comb begin
      unique case (ctl.rd_sel)
         RD_FIRST: rd_addr = '0;
         RD_NEXT:  rd_addr = idx_ff + IDX_W'(1);
         RD_TAIL:  rd_addr = tail_idx;
         default:  rd_addr = '0;
      endcase
   end

   assign wr_en   = ctl.do_send || ctl.do_retx || ctl.do_move;
   assign wr_addr = ctl.do_send ? pending_ff[IDX_W-1:0] : idx_ff;

   always_comb begin
      priority if (ctl.do_send) begin
         wr_data = {next_id_ff, now_ff};
      end else if (ctl.do_retx) begin
         wr_data = {rd_id, now_ff};
      end else begin
         wr_data = rd_data;
      end
   end

   art_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (ctl.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      unique case (ctl.kind)
         KIND_SENT, KIND_FULL:                        msg_in = next_id_ff;
         KIND_RETX:                                   msg_in = rd_id;
         KIND_ACK_HIT, KIND_ACK_MISS, KIND_ACK_REPLY: msg_in = fid_ff;
         KIND_TICK_DONE:                              msg_in = now_ff;
         default:                                     msg_in = fid_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= '0;
         next_id_ff   <= '0;
         now_ff       <= '0;
         tx_ff        <= '0;
         age_ff       <= RETRY_AGE_RESET;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         next_id_ff <= next_id_in;
         now_ff     <= now_in;
         tx_ff      <= tx_in;
         if (csr_valid) begin
            age_ff <= csr_data;
         end
         if (ctl.idx_clr) begin
            idx_ff <= '0;
         end else if (ctl.idx_inc) begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
         if (ctl.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.latch) begin
         fid_ff <= req_frame_id;
      end
      if (ctl.emit) begin
         kind_ff  <= ctl.kind;
         msg_ff   <= msg_in;
         pcnt_ff  <= PEND_W'(pending_in);
         total_ff <= tx_in;
         last_ff  <= ctl.last;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.kind           = kind_ff;
   assign rsp_chan.msg_id         = msg_ff;
   assign rsp_chan.pending_count  = pcnt_ff;
   assign rsp_chan.transmit_total = total_ff;
   assign rsp_chan.last           = last_ff;

   assign sts.pending_zero = (pending_ff == '0);
   assign sts.full         = (pending_ff == CNT_W'(TABLE_DEPTH));
   assign sts.id_match     = (rd_id == fid_ff);
   assign sts.at_tail      = (CNT_W'(idx_ff) == tail_cnt);
   assign sts.age_due      = (age >= ID_W'(age_ff));
   assign sts.out_free     = !rsp_valid_ff || rsp_chan.ready;

endmodule

@@ rtl/arq_retransmit_tracker_unit.sv @@
// ARQ retransmit tracker top level: tracks unacknowledged message ids with
// their send time and retransmits them on tick. Depends on art_pkg, art_if,
// art_ctrl, art_dp.
//
// One request is handled at a time. An ack compares one table entry per
// cycle out of the entry RAM, and a tick visits every pending entry; a
// request also waits while the response side holds ready low and a result
// waits. The entry table holds 32 entries. The next request is taken while
// the last result still sits in the output register. retry_age resets to 4
// and may be written at any time the block is idle; the configuration
// channel is always ready. The entry table needs no clearing after reset.
module arq_retransmit_tracker_unit import art_pkg::*; (
   input logic       clock,
   input logic       reset,
   art_req_if.sink   req_chan,
   art_rsp_if.source rsp_chan,
   art_csr_if.sink   csr_chan
);

   dp_cmd_type    ctl;
   dp_status_type sts;
   logic          req_ready;

   assign req_chan.ready = req_ready;
   assign csr_chan.ready = 1'b1;

   art_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_cmd   (req_chan.cmd),
      .req_ready (req_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   art_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .sts          (sts),
      .req_frame_id (req_chan.frame_id),
      .csr_valid    (csr_chan.valid),
      .csr_data     (csr_chan.data),
      .rsp_chan     (rsp_chan)
   );

endmodule
